/* rtl/osp_pkg.sv */
`timescale 1ns / 1ps

package osp_pkg;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_ADDR    = 2'd1,
      PH_LEN     = 2'd2,
      PH_PAYLOAD = 2'd3
   } phase_type;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_CODE  = 2'd0;
   localparam kind_type KIND_DATA  = 2'd1;
   localparam kind_type KIND_LABEL = 2'd2;

   localparam logic [7:0] HDR_CODE_HI  = 8'hca;
   localparam logic [7:0] HDR_CODE_LO  = 8'hde;
   localparam logic [7:0] HDR_DATA_HI  = 8'hda;
   localparam logic [7:0] HDR_DATA_LO  = 8'hda;
   localparam logic [7:0] HDR_LABEL_HI = 8'hc3;
   localparam logic [7:0] HDR_LABEL_LO = 8'hb7;

endpackage

/* rtl/object_section_stream_parser.sv */
`timescale 1ns / 1ps

// Parses an object image that arrives one byte per transaction. Bytes are paired
// big-endian into words; the words 0xCADE, 0xDADA and 0xC3B7 open a code, data or
// label section, each followed by an address word and a length word. Code and data
// sections give one record per payload word at an incrementing address, label
// sections one record per payload byte at the label address, and the final record
// of a section has rsp_last set. A section of length zero gives no record. The
// block takes one byte per cycle while results are taken: a byte passes through
// an input register and is parsed in the single step from there into the result
// register, so a byte may be accepted while a result still waits to be taken.
module object_section_stream_parser
   import osp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_address,
   output logic [15:0] rsp_value,
   output logic        rsp_last
);

   logic        in_vld_ff, in_vld_in;
   logic [7:0]  in_byte_ff;
   logic        out_free, advance;

   phase_type   phase_ff, phase_in;
   kind_type    kind_ff, kind_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [7:0]  hold_ff, hold_in;
   logic        parity_ff, parity_in;

   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    rsp_kind_ff, rsp_kind_in;
   logic [15:0] rsp_address_ff, rsp_address_in;
   logic [15:0] rsp_value_ff, rsp_value_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        label_pay, word_done, emit, count_end;
   logic [15:0] word;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_vld_ff && out_free;
   assign req_ready = !in_vld_ff || out_free;

   assign in_vld_in = (req_valid && req_ready) || (in_vld_ff && !advance);

   assign label_pay = (phase_ff == PH_PAYLOAD) && (kind_ff == KIND_LABEL);
   assign word_done = !label_pay && parity_ff;
   assign word      = {hold_ff, in_byte_ff};
   assign count_end = (cnt_ff == 16'd1);
   assign emit      = advance && (phase_ff == PH_PAYLOAD) && (label_pay || parity_ff);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         if (label_pay) begin
            if (count_end) begin
               phase_in = PH_HEADER;
            end
         end else if (word_done) begin
            unique case (phase_ff)
               PH_HEADER: begin
                  if ((hold_ff == HDR_CODE_HI && in_byte_ff == HDR_CODE_LO) ||
                      (hold_ff == HDR_DATA_HI && in_byte_ff == HDR_DATA_LO) ||
                      (hold_ff == HDR_LABEL_HI && in_byte_ff == HDR_LABEL_LO)) begin
                     phase_in = PH_ADDR;
                  end
               end
               PH_ADDR:    phase_in = PH_LEN;
               PH_LEN:     phase_in = (word != 16'd0) ? PH_PAYLOAD : PH_HEADER;
               PH_PAYLOAD: phase_in = count_end ? PH_HEADER : PH_PAYLOAD;
               default:    phase_in = PH_HEADER;
            endcase
         end
      end
   end

   // Data path and result.
   always_comb begin
      kind_in        = kind_ff;
      addr_in        = addr_ff;
      cnt_in         = cnt_ff;
      hold_in        = hold_ff;
      parity_in      = parity_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_address_in = rsp_address_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      if (advance) begin
         rsp_valid_in = emit;
         if (label_pay) begin
            rsp_kind_in    = KIND_LABEL;
            rsp_address_in = addr_ff;
            rsp_value_in   = {8'd0, in_byte_ff};
            rsp_last_in    = count_end;
            cnt_in         = cnt_ff - 16'd1;
            if (count_end) begin
               parity_in = 1'b0;
            end
         end else if (!parity_ff) begin
            hold_in   = in_byte_ff;
            parity_in = 1'b1;
         end else begin
            parity_in = 1'b0;
            unique case (phase_ff)
               PH_HEADER: begin
                  priority if (hold_ff == HDR_CODE_HI && in_byte_ff == HDR_CODE_LO) begin
                     kind_in = KIND_CODE;
                  end else if (hold_ff == HDR_DATA_HI && in_byte_ff == HDR_DATA_LO) begin
                     kind_in = KIND_DATA;
                  end else if (hold_ff == HDR_LABEL_HI && in_byte_ff == HDR_LABEL_LO) begin
                     kind_in = KIND_LABEL;
                  end else begin
                     kind_in = kind_ff;
                  end
               end
               PH_ADDR: addr_in = word;
               PH_LEN:  cnt_in  = word;
               PH_PAYLOAD: begin
                  rsp_kind_in    = kind_ff;
                  rsp_address_in = addr_ff;
                  rsp_value_in   = word;
                  rsp_last_in    = count_end;
                  addr_in        = addr_ff + 16'd1;
                  cnt_in         = cnt_ff - 16'd1;
               end
               default: kind_in = kind_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         phase_ff     <= PH_HEADER;
         kind_ff      <= KIND_CODE;
         addr_ff      <= 16'd0;
         cnt_ff       <= 16'd0;
         hold_ff      <= 8'd0;
         parity_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_vld_ff    <= in_vld_in;
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         addr_ff      <= addr_in;
         cnt_ff       <= cnt_in;
         hold_ff      <= hold_in;
         parity_ff    <= parity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
      rsp_kind_ff    <= rsp_kind_in;
      rsp_address_ff <= rsp_address_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_address = rsp_address_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_last    = rsp_last_ff;

   // A payload section always has records left to give.
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> cnt_ff != 16'd0)
      else $error("payload phase with zero remaining count");

   // Label payload bytes are taken one at a time, never mid-word.
   a_label_parity: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD && kind_ff == KIND_LABEL) |-> !parity_ff)
      else $error("label payload entered with a half word pending");

   // The final record of a section returns the parser to header search.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (emit && count_end) |=> (phase_ff == PH_HEADER && !parity_ff))
      else $error("section did not end after its last record");

   // A result is only produced from a byte held in the input register.
   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(in_vld_ff))
      else $error("result without a byte to produce it");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_kind_ff == KIND_CODE || rsp_kind_ff == KIND_DATA ||
                        rsp_kind_ff == KIND_LABEL))
      else $error("result carries an undefined record kind");

endmodule

/* dv/tb_object_section_stream_parser.sv */
`timescale 1ns / 1ps

module tb_object_section_stream_parser;
   import osp_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] address;
      logic [15:0] value;
      logic        last;
   } section_record_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_address;
   logic [15:0] rsp_value;
   logic        rsp_last;

   // Shadow of the parser state, advanced on every accepted byte.
   phase_type   parse_phase = PH_HEADER;
   kind_type    sect_kind = KIND_CODE;
   logic [15:0] sect_addr = 16'h0000;
   logic [15:0] sect_left = 16'h0000;
   logic [7:0]  hi_byte = 8'h00;
   logic        have_hi = 1'b0;

   section_record_type pending_records[$];
   bit          calm = 1'b0;
   int unsigned fail_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned records_checked = 0;
   int unsigned quiet_cycles = 0;

   object_section_stream_parser i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_kind    (rsp_kind),
      .rsp_address (rsp_address),
      .rsp_value   (rsp_value),
      .rsp_last    (rsp_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void parse_byte(input logic [7:0] b);
      logic [15:0] w;
      section_record_type rec;
      rec.kind    = sect_kind;
      rec.address = sect_addr;
      rec.value   = 16'h0000;
      rec.last    = (sect_left == 16'd1);
      if (parse_phase == PH_PAYLOAD && sect_kind == KIND_LABEL) begin
         // Label payload is taken byte by byte, outside the word pairing.
         rec.value = {8'h00, b};
         pending_records.push_back(rec);
         sect_left = sect_left - 16'd1;
      end else if (!have_hi) begin
         hi_byte = b;
         have_hi = 1'b1;
      end else begin
         have_hi = 1'b0;
         w = {hi_byte, b};
         case (parse_phase)
            PH_ADDR: begin
               sect_addr = w;
               parse_phase = PH_LEN;
            end
            PH_LEN: begin
               sect_left = w;
               if (w != 16'd0) parse_phase = PH_PAYLOAD;
               else parse_phase = PH_HEADER;
            end
            PH_PAYLOAD: begin
               rec.value = w;
               pending_records.push_back(rec);
               sect_addr = sect_addr + 16'd1;
               sect_left = sect_left - 16'd1;
            end
            default: begin
               if (w == {HDR_CODE_HI, HDR_CODE_LO}) begin
                  sect_kind = KIND_CODE;
                  parse_phase = PH_ADDR;
               end else if (w == {HDR_DATA_HI, HDR_DATA_LO}) begin
                  sect_kind = KIND_DATA;
                  parse_phase = PH_ADDR;
               end else if (w == {HDR_LABEL_HI, HDR_LABEL_LO}) begin
                  sect_kind = KIND_LABEL;
                  parse_phase = PH_ADDR;
               end
            end
         endcase
      end
      // The end of a section also restarts the byte pairing.
      if (parse_phase == PH_PAYLOAD && sect_left == 16'd0) begin
         parse_phase = PH_HEADER;
         have_hi = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      section_record_type exp_rec;
      if (reset) begin
         parse_phase = PH_HEADER;
         sect_kind = KIND_CODE;
         sect_addr = 16'h0000;
         sect_left = 16'h0000;
         hi_byte = 8'h00;
         have_hi = 1'b0;
         pending_records.delete();
      end else begin
         if (req_valid && req_ready) begin
            parse_byte(req_in_byte);
            bytes_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_records.size() == 0) begin
               $error("unexpected record: kind %0d address %h value %h last %0d",
                      rsp_kind, rsp_address, rsp_value, rsp_last);
               fail_count++;
            end else begin
               exp_rec = pending_records.pop_front();
               records_checked++;
               if (rsp_kind !== exp_rec.kind) begin
                  $error("rsp_kind mismatch: expected %0d, actual %0d", exp_rec.kind, rsp_kind);
                  fail_count++;
               end
               if (rsp_address !== exp_rec.address) begin
                  $error("rsp_address mismatch: expected %h, actual %h",
                         exp_rec.address, rsp_address);
                  fail_count++;
               end
               if (rsp_value !== exp_rec.value) begin
                  $error("rsp_value mismatch: expected %h, actual %h", exp_rec.value, rsp_value);
                  fail_count++;
               end
               if (rsp_last !== exp_rec.last) begin
                  $error("rsp_last mismatch: expected %0d, actual %0d", exp_rec.last, rsp_last);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 36);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d records outstanding", pending_records.size());
         $display("tb_object_section_stream_parser: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while (!calm && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // The extra edge lets the monitor account for a byte accepted in this time step.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_records.size() != 0) @(posedge clock);
   endtask

   // Two code words, the first at 0xFFFF so the address wraps; the second looks like a header.
   task automatic test_code_wrap();
      logic [7:0] image [10];
      image = '{HDR_CODE_HI, HDR_CODE_LO, 8'hFF, 8'hFF, 8'h00, 8'h02,
                8'hFF, 8'hFF, HDR_CODE_HI, HDR_CODE_LO};
      foreach (image[i]) send_byte(image[i]);
   endtask

   // Three label characters; the next test starts right after the odd byte count.
   task automatic test_label_odd_length();
      logic [7:0] image [9];
      image = '{HDR_LABEL_HI, HDR_LABEL_LO, 8'hAB, 8'hCD, 8'h00, 8'h03,
                8'h00, 8'hFF, 8'h80};
      foreach (image[i]) send_byte(image[i]);
   endtask

   // An unknown word, an empty code section, then one data word that looks like a label header.
   task automatic test_unknown_empty_data();
      logic [7:0] image [16];
      image = '{8'h00, 8'h00, HDR_CODE_HI, HDR_CODE_LO, 8'h12, 8'h34, 8'h00, 8'h00,
                HDR_DATA_HI, HDR_DATA_LO, 8'h80, 8'h00, 8'h00, 8'h01,
                HDR_LABEL_HI, HDR_LABEL_LO};
      foreach (image[i]) send_byte(image[i]);
   endtask

   task automatic test_random_sections(input int unsigned n_bytes, input bit no_idle);
      int unsigned sent;
      int unsigned n;
      kind_type    k;
      logic [15:0] addr;
      logic [15:0] len;
      logic [15:0] w;
      calm = no_idle;
      sent = 0;
      while (sent < n_bytes) begin
         if ($urandom_range(7) == 0) begin
            // Noise words, often a near miss of a header; whole words keep the pairing aligned.
            repeat ($urandom_range(1, 3)) begin
               w[7:0] = 8'($urandom_range(255));
               case ($urandom_range(3))
                  0: w[15:8] = HDR_CODE_HI;
                  1: w[15:8] = HDR_DATA_HI;
                  2: w[15:8] = HDR_LABEL_HI;
                  default: w[15:8] = 8'($urandom_range(255));
               endcase
               if (w == {HDR_CODE_HI, HDR_CODE_LO} || w == {HDR_DATA_HI, HDR_DATA_LO} ||
                   w == {HDR_LABEL_HI, HDR_LABEL_LO}) begin
                  w[0] = ~w[0];
               end
               send_byte(w[15:8]);
               send_byte(w[7:0]);
            end
         end else begin
            k = kind_type'($urandom_range(2));
            if ($urandom_range(3) == 0) addr = 16'hFFFF - 16'($urandom_range(3));
            else addr = 16'($urandom);
            case ($urandom_range(15))
               0: len = 16'd0;
               1: len = 16'($urandom_range(12, 30));
               default: len = 16'($urandom_range(1, 6));
            endcase
            case (k)
               KIND_CODE: begin
                  send_byte(HDR_CODE_HI);
                  send_byte(HDR_CODE_LO);
               end
               KIND_DATA: begin
                  send_byte(HDR_DATA_HI);
                  send_byte(HDR_DATA_LO);
               end
               default: begin
                  send_byte(HDR_LABEL_HI);
                  send_byte(HDR_LABEL_LO);
               end
            endcase
            send_byte(addr[15:8]);
            send_byte(addr[7:0]);
            send_byte(len[15:8]);
            send_byte(len[7:0]);
            if (k == KIND_LABEL) n = len;
            else n = 2 * len;
            repeat (n) begin
               case ($urandom_range(15))
                  0: w[7:0] = HDR_CODE_HI;
                  1: w[7:0] = HDR_CODE_LO;
                  2: w[7:0] = HDR_DATA_HI;
                  3: w[7:0] = HDR_LABEL_HI;
                  4: w[7:0] = HDR_LABEL_LO;
                  default: w[7:0] = 8'($urandom_range(255));
               endcase
               send_byte(w[7:0]);
            end
            sent += 6 + n;
            if ($urandom_range(15) == 0) wait_drained();
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_code_wrap();
      test_label_odd_length();
      test_unknown_empty_data();
      wait_drained();
      test_random_sections(450, 1'b0);
      wait_drained();
      test_random_sections(150, 1'b1);

      wait_drained();
      repeat (20) @(posedge clock);
      if (pending_records.size() != 0) begin
         $error("%0d expected records never arrived", pending_records.size());
         fail_count += pending_records.size();
      end
      $display("Covered code, data and label sections, empty and odd sections, noise words");
      $display("and address wrap: %0d bytes sent, %0d records compared.",
               bytes_sent, records_checked);
      if (fail_count == 0) begin
         $display("tb_object_section_stream_parser: PASS");
      end else begin
         $display("tb_object_section_stream_parser: FAIL");
      end
      $finish;
   end

endmodule
